/* hw/rtl/clnws_pkg.sv */
package clnws_pkg;

  localparam int CountWidth = 24;
  localparam int RegWidth   = 24;
  localparam int DataWidth  = 32;
  localparam int AddrWidth  = 5;
  localparam int NumRegs    = 8;
  localparam int RegIdxW    = $clog2(NumRegs);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // register indexes
  localparam logic [RegIdxW-1:0] RegSetup    = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegPulse    = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] RegHold     = RegIdxW'(2);
  localparam logic [RegIdxW-1:0] RegGap      = RegIdxW'(3);
  localparam logic [RegIdxW-1:0] RegSettle   = RegIdxW'(4);
  localparam logic [RegIdxW-1:0] RegSlow     = RegIdxW'(5);
  localparam logic [RegIdxW-1:0] RegPowerup  = RegIdxW'(6);
  localparam logic [RegIdxW-1:0] RegInitStep = RegIdxW'(7);

  localparam logic [RegWidth-1:0] SetupReset    = RegWidth'(72);
  localparam logic [RegWidth-1:0] PulseReset    = RegWidth'(540);
  localparam logic [RegWidth-1:0] HoldReset     = RegWidth'(24);
  localparam logic [RegWidth-1:0] GapReset      = RegWidth'(540);
  localparam logic [RegWidth-1:0] SettleReset   = RegWidth'(52);
  localparam logic [RegWidth-1:0] SlowReset     = RegWidth'(1824);
  localparam logic [RegWidth-1:0] PowerupReset  = RegWidth'(24000);
  localparam logic [RegWidth-1:0] InitStepReset = RegWidth'(480);

  // input kind codes
  localparam logic [1:0] KindTick  = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindInit  = 2'd2;
  localparam logic [1:0] KindNone  = 2'd3;

  localparam logic [7:0] CmdFunctionSet = 8'h28;
  localparam logic [7:0] CmdDisplayOn   = 8'h0C;
  localparam logic [7:0] CmdClear       = 8'h01;
  localparam logic [7:0] CmdHomeLast    = 8'h03;
  localparam logic [3:0] NibbleWake     = 4'h3;
  localparam logic [3:0] NibbleFourBit  = 4'h2;

  localparam logic [2:0] InitIdxLastWake = 3'd3;
  localparam logic [2:0] InitIdxFirstCmd = 3'd4;
  localparam logic [2:0] InitIdxLastCmd  = 3'd6;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_WRITE,
    OP_INIT,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] byte_value;
    logic       is_data;
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_W_SETUP_HI,
    PH_W_PULSE_HI,
    PH_W_HOLD_HI,
    PH_W_GAP,
    PH_W_SETUP_LO,
    PH_W_PULSE_LO,
    PH_W_HOLD_LO,
    PH_W_SETTLE,
    PH_W_SLOW,
    PH_I_POWER,
    PH_I_SETUP,
    PH_I_PULSE,
    PH_I_HOLD,
    PH_I_STEP
  } phase_t;

  typedef struct packed {
    logic [RegWidth-1:0] setup_ticks;
    logic [RegWidth-1:0] pulse_ticks;
    logic [RegWidth-1:0] hold_ticks;
    logic [RegWidth-1:0] gap_ticks;
    logic [RegWidth-1:0] settle_ticks;
    logic [RegWidth-1:0] slow_ticks;
    logic [RegWidth-1:0] powerup_ticks;
    logic [RegWidth-1:0] init_step_ticks;
  } cfg_t;

  // clamp a register value into the delay counter
  function automatic logic [CountWidth-1:0] sat_count(input logic [RegWidth-1:0] v);
    logic [RegWidth-1:0] upper;
    upper = v >> CountWidth;
    if (RegWidth > CountWidth && upper != '0) begin
      return '1;
    end
    return CountWidth'(v);
  endfunction

  // commands sent after the wake-up nibbles
  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = CmdFunctionSet;
      2'd1: c = CmdDisplayOn;
      2'd2: c = CmdClear;
      2'd3: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/clnws_cfg.sv */
module clnws_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [clnws_pkg::AddrWidth-1:0]     paddr,
  input  logic [clnws_pkg::DataWidth-1:0]     pwdata,
  output logic [clnws_pkg::DataWidth-1:0]     prdata,
  output logic                                pready,
  output clnws_pkg::cfg_t                     cfg
);

  logic                            wr_en;
  logic [clnws_pkg::RegIdxW-1:0]   idx;
  logic [clnws_pkg::RegWidth-1:0]  wval;
  logic [clnws_pkg::RegWidth-1:0]  rval;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[clnws_pkg::AddrWidth-1:2];
  assign wval   = pwdata[clnws_pkg::RegWidth-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setup_ticks     <= clnws_pkg::SetupReset;
      cfg.pulse_ticks     <= clnws_pkg::PulseReset;
      cfg.hold_ticks      <= clnws_pkg::HoldReset;
      cfg.gap_ticks       <= clnws_pkg::GapReset;
      cfg.settle_ticks    <= clnws_pkg::SettleReset;
      cfg.slow_ticks      <= clnws_pkg::SlowReset;
      cfg.powerup_ticks   <= clnws_pkg::PowerupReset;
      cfg.init_step_ticks <= clnws_pkg::InitStepReset;
    end else if (wr_en) begin
      unique case (idx)
        clnws_pkg::RegSetup:    cfg.setup_ticks     <= wval;
        clnws_pkg::RegPulse:    cfg.pulse_ticks     <= wval;
        clnws_pkg::RegHold:     cfg.hold_ticks      <= wval;
        clnws_pkg::RegGap:      cfg.gap_ticks       <= wval;
        clnws_pkg::RegSettle:   cfg.settle_ticks    <= wval;
        clnws_pkg::RegSlow:     cfg.slow_ticks      <= wval;
        clnws_pkg::RegPowerup:  cfg.powerup_ticks   <= wval;
        clnws_pkg::RegInitStep: cfg.init_step_ticks <= wval;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      clnws_pkg::RegSetup:    rval = cfg.setup_ticks;
      clnws_pkg::RegPulse:    rval = cfg.pulse_ticks;
      clnws_pkg::RegHold:     rval = cfg.hold_ticks;
      clnws_pkg::RegGap:      rval = cfg.gap_ticks;
      clnws_pkg::RegSettle:   rval = cfg.settle_ticks;
      clnws_pkg::RegSlow:     rval = cfg.slow_ticks;
      clnws_pkg::RegPowerup:  rval = cfg.powerup_ticks;
      clnws_pkg::RegInitStep: rval = cfg.init_step_ticks;
    endcase
  end

  assign prdata = clnws_pkg::DataWidth'(rval);

endmodule

/* hw/rtl/clnws_front.sv */
module clnws_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [7:0]        byte_value,
  input  logic              is_data,
  output logic              cmd_valid,
  output clnws_pkg::cmd_t   cmd,
  input  logic              cmd_pop
);

  clnws_pkg::cmd_t                 entry [clnws_pkg::QueueDepth];
  clnws_pkg::cmd_t                 in_cmd;
  logic [clnws_pkg::QPtrW-1:0]     wr_ptr;
  logic [clnws_pkg::QPtrW-1:0]     rd_ptr;
  logic [clnws_pkg::QCntW-1:0]     count;
  logic                            push;
  logic                            pop;

  always_comb begin
    unique case (kind)
      clnws_pkg::KindTick:  in_cmd.op = clnws_pkg::OP_TICK;
      clnws_pkg::KindWrite: in_cmd.op = clnws_pkg::OP_WRITE;
      clnws_pkg::KindInit:  in_cmd.op = clnws_pkg::OP_INIT;
      clnws_pkg::KindNone:  in_cmd.op = clnws_pkg::OP_NOP;
    endcase
    in_cmd.byte_value = byte_value;
    in_cmd.is_data    = is_data;
  end

  assign in_stall  = (count == clnws_pkg::QCntW'(clnws_pkg::QueueDepth));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + clnws_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + clnws_pkg::QPtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + clnws_pkg::QCntW'(1);
        2'b01:   count <= count - clnws_pkg::QCntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/clnws_back.sv */
module clnws_back (
  input  logic              clk,
  input  logic              rst,
  input  clnws_pkg::cfg_t   cfg,
  input  logic              cmd_valid,
  input  clnws_pkg::cmd_t   cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              enable_pin,
  output logic              select_pin,
  output logic [3:0]        nibble_out,
  output logic              bus_drive,
  output logic              busy_res,
  output logic              rejected
);

  clnws_pkg::phase_t                  phase, phase_next;
  logic [clnws_pkg::CountWidth-1:0]   delay_left, delay_left_next;
  logic [7:0]                         held_byte, held_byte_next;
  logic                               held_select, held_select_next;
  logic [2:0]                         init_index, init_index_next;
  logic                               pin_enable, pin_enable_next;
  logic                               pin_select, pin_select_next;
  logic [3:0]                         pin_nibble, pin_nibble_next;
  logic                               pin_drive, pin_drive_next;

  logic                               busy;
  logic                               tick;
  logic                               tick_dec;
  logic                               tick_done;
  logic                               req;
  logic                               rej;
  logic                               start_w;
  logic                               start_i;
  logic                               slow_needed;
  logic                               more_cmds;
  logic                               bw;
  logic [7:0]                         bw_byte;
  logic                               bw_sel;
  logic [2:0]                         idx_inc;
  logic [clnws_pkg::RegWidth-1:0]     load_ticks;

  assign cmd_pop = cmd_valid && (!out_valid || !out_stall);

  // item decode
  always_comb begin
    busy      = (phase != clnws_pkg::PH_IDLE);
    tick      = cmd_pop && (cmd.op == clnws_pkg::OP_TICK) && busy;
    tick_dec  = tick && (delay_left > clnws_pkg::CountWidth'(1));
    tick_done = tick && !tick_dec;
    req       = cmd_pop && (cmd.op == clnws_pkg::OP_WRITE || cmd.op == clnws_pkg::OP_INIT);
    rej       = req && busy;
    start_w   = req && !busy && (cmd.op == clnws_pkg::OP_WRITE);
    start_i   = req && !busy && (cmd.op == clnws_pkg::OP_INIT);
    idx_inc   = init_index + 3'd1;
    // clear and home commands need the long wait
    slow_needed = !held_select && held_byte >= clnws_pkg::CmdClear
                  && held_byte <= clnws_pkg::CmdHomeLast;
    more_cmds = (init_index >= clnws_pkg::InitIdxFirstCmd)
                && (init_index < clnws_pkg::InitIdxLastCmd);
    bw = start_w
         || (tick_done && phase == clnws_pkg::PH_W_SETTLE && !slow_needed && more_cmds)
         || (tick_done && phase == clnws_pkg::PH_W_SLOW && more_cmds)
         || (tick_done && phase == clnws_pkg::PH_I_STEP && init_index >= clnws_pkg::InitIdxLastWake);
    if (start_w) begin
      bw_byte = cmd.byte_value;
      bw_sel  = cmd.is_data;
    end else if (phase == clnws_pkg::PH_I_STEP) begin
      bw_byte = clnws_pkg::CmdFunctionSet;
      bw_sel  = 1'b0;
    end else begin
      bw_byte = clnws_pkg::init_cmd(2'(idx_inc - clnws_pkg::InitIdxFirstCmd));
      bw_sel  = 1'b0;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (bw) begin
      phase_next = clnws_pkg::PH_W_SETUP_HI;
    end else if (start_i) begin
      phase_next = clnws_pkg::PH_I_POWER;
    end else if (tick_done) begin
      unique case (phase)
        clnws_pkg::PH_W_SETUP_HI: phase_next = clnws_pkg::PH_W_PULSE_HI;
        clnws_pkg::PH_W_PULSE_HI: phase_next = clnws_pkg::PH_W_HOLD_HI;
        clnws_pkg::PH_W_HOLD_HI:  phase_next = clnws_pkg::PH_W_GAP;
        clnws_pkg::PH_W_GAP:      phase_next = clnws_pkg::PH_W_SETUP_LO;
        clnws_pkg::PH_W_SETUP_LO: phase_next = clnws_pkg::PH_W_PULSE_LO;
        clnws_pkg::PH_W_PULSE_LO: phase_next = clnws_pkg::PH_W_HOLD_LO;
        clnws_pkg::PH_W_HOLD_LO:  phase_next = clnws_pkg::PH_W_SETTLE;
        clnws_pkg::PH_W_SETTLE:
          phase_next = slow_needed ? clnws_pkg::PH_W_SLOW : clnws_pkg::PH_IDLE;
        clnws_pkg::PH_I_POWER:    phase_next = clnws_pkg::PH_I_SETUP;
        clnws_pkg::PH_I_SETUP:    phase_next = clnws_pkg::PH_I_PULSE;
        clnws_pkg::PH_I_PULSE:    phase_next = clnws_pkg::PH_I_HOLD;
        clnws_pkg::PH_I_HOLD:     phase_next = clnws_pkg::PH_I_STEP;
        clnws_pkg::PH_I_STEP:     phase_next = clnws_pkg::PH_I_SETUP;
        default:                  phase_next = clnws_pkg::PH_IDLE;
      endcase
    end
  end

  // delay to load on entering a phase
  always_comb begin
    unique case (phase_next)
      clnws_pkg::PH_W_SETUP_HI,
      clnws_pkg::PH_W_SETUP_LO,
      clnws_pkg::PH_I_SETUP:    load_ticks = cfg.setup_ticks;
      clnws_pkg::PH_W_PULSE_HI,
      clnws_pkg::PH_W_PULSE_LO,
      clnws_pkg::PH_I_PULSE:    load_ticks = cfg.pulse_ticks;
      clnws_pkg::PH_W_HOLD_HI,
      clnws_pkg::PH_W_HOLD_LO,
      clnws_pkg::PH_I_HOLD:     load_ticks = cfg.hold_ticks;
      clnws_pkg::PH_W_GAP:      load_ticks = cfg.gap_ticks;
      clnws_pkg::PH_W_SETTLE:   load_ticks = cfg.settle_ticks;
      clnws_pkg::PH_W_SLOW:     load_ticks = cfg.slow_ticks;
      clnws_pkg::PH_I_POWER:    load_ticks = cfg.powerup_ticks;
      clnws_pkg::PH_I_STEP:     load_ticks = cfg.init_step_ticks;
      default:                  load_ticks = '0;
    endcase
  end

  // counter, held byte and pins
  always_comb begin
    delay_left_next  = delay_left;
    held_byte_next   = held_byte;
    held_select_next = held_select;
    init_index_next  = init_index;
    pin_enable_next  = pin_enable;
    pin_select_next  = pin_select;
    pin_nibble_next  = pin_nibble;
    pin_drive_next   = pin_drive;

    if (tick_dec) begin
      delay_left_next = delay_left - clnws_pkg::CountWidth'(1);
    end else if (tick_done || start_w || start_i) begin
      delay_left_next = clnws_pkg::sat_count(load_ticks);
    end

    if (start_w) begin
      init_index_next = '0;
    end else if (start_i) begin
      init_index_next = '0;
      pin_drive_next  = 1'b0;
      pin_select_next = 1'b0;
      pin_enable_next = 1'b0;
      pin_nibble_next = '0;
    end else if (tick_done) begin
      unique case (phase)
        clnws_pkg::PH_W_SETUP_HI,
        clnws_pkg::PH_W_SETUP_LO,
        clnws_pkg::PH_I_SETUP:    pin_enable_next = 1'b1;
        clnws_pkg::PH_W_PULSE_HI,
        clnws_pkg::PH_W_PULSE_LO,
        clnws_pkg::PH_I_PULSE:    pin_enable_next = 1'b0;
        clnws_pkg::PH_W_HOLD_HI,
        clnws_pkg::PH_I_HOLD:     pin_enable_next = pin_enable;
        clnws_pkg::PH_W_GAP:      pin_nibble_next = held_byte[3:0];
        clnws_pkg::PH_W_HOLD_LO: begin
          pin_drive_next  = 1'b0;
          pin_select_next = 1'b0;
          pin_enable_next = 1'b0;
          pin_nibble_next = '0;
        end
        clnws_pkg::PH_W_SETTLE: begin
          if (!slow_needed) begin
            init_index_next = more_cmds ? idx_inc : 3'd0;
          end
        end
        clnws_pkg::PH_W_SLOW:     init_index_next = more_cmds ? idx_inc : 3'd0;
        clnws_pkg::PH_I_POWER: begin
          pin_drive_next  = 1'b1;
          pin_select_next = 1'b0;
          pin_enable_next = 1'b0;
          pin_nibble_next = clnws_pkg::NibbleWake;
          init_index_next = '0;
        end
        clnws_pkg::PH_I_STEP: begin
          if (init_index < clnws_pkg::InitIdxLastWake) begin
            init_index_next = idx_inc;
            pin_nibble_next = (idx_inc == clnws_pkg::InitIdxLastWake) ?
                              clnws_pkg::NibbleFourBit : clnws_pkg::NibbleWake;
          end else begin
            init_index_next = clnws_pkg::InitIdxFirstCmd;
          end
        end
        default:                  init_index_next = '0;
      endcase
    end

    // start of a byte write overrides the pins
    if (bw) begin
      held_byte_next   = bw_byte;
      held_select_next = bw_sel;
      pin_drive_next   = 1'b1;
      pin_select_next  = bw_sel;
      pin_enable_next  = 1'b0;
      pin_nibble_next  = bw_byte[7:4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= clnws_pkg::PH_IDLE;
      delay_left  <= '0;
      held_byte   <= '0;
      held_select <= 1'b0;
      init_index  <= '0;
      pin_enable  <= 1'b0;
      pin_select  <= 1'b0;
      pin_nibble  <= '0;
      pin_drive   <= 1'b0;
    end else if (cmd_pop) begin
      phase       <= phase_next;
      delay_left  <= delay_left_next;
      held_byte   <= held_byte_next;
      held_select <= held_select_next;
      init_index  <= init_index_next;
      pin_enable  <= pin_enable_next;
      pin_select  <= pin_select_next;
      pin_nibble  <= pin_nibble_next;
      pin_drive   <= pin_drive_next;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      enable_pin <= pin_enable_next;
      select_pin <= pin_select_next;
      nibble_out <= pin_nibble_next;
      bus_drive  <= pin_drive_next;
      busy_res   <= (phase_next != clnws_pkg::PH_IDLE);
      rejected   <= rej;
    end
  end

endmodule

/* hw/rtl/char_lcd_nibble_write_sequencer.sv */
// Path: an accepted word is held in the queue and then registered in the result register
// once that register is free.
// Throughput: one word per cycle; the sequencer retires one queued word each cycle
// the result register is free, behind a two-entry queue.
// Reset (rst, synchronous): timing registers to defaults, sequencer idle with its pin state
// released, queue and result register empty; the pin outputs themselves are not reset.
module char_lcd_nibble_write_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [clnws_pkg::AddrWidth-1:0]   paddr,
  input  logic [clnws_pkg::DataWidth-1:0]   pwdata,
  output logic [clnws_pkg::DataWidth-1:0]   prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        kind,
  input  logic [7:0]                        byte_value,
  input  logic                              is_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              enable_pin,
  output logic                              select_pin,
  output logic                              rw_pin,
  output logic [3:0]                        nibble_out,
  output logic                              bus_drive,
  output logic                              busy_res,
  output logic                              rejected
);

  clnws_pkg::cfg_t  cfg;
  clnws_pkg::cmd_t  cmd;
  logic             cmd_valid;
  logic             cmd_pop;

  assign rw_pin = 1'b0;

  clnws_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  clnws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .byte_value (byte_value),
    .is_data    (is_data),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  clnws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .enable_pin (enable_pin),
    .select_pin (select_pin),
    .nibble_out (nibble_out),
    .bus_drive  (bus_drive),
    .busy_res   (busy_res),
    .rejected   (rejected)
  );

endmodule
